>>> sv/wss_pkg.sv
package wss_pkg;

   // fixed field widths of the channels and the store
   localparam int SUM_W      = 32;
   localparam int SQ_W       = 45;
   localparam int POS_W      = 8;
   localparam int FEAT_W     = 45;
   localparam int FIDX_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // std dev is Q.8, so the variance is scaled by 2^16 before the root
   localparam int FRAC_SHIFT = 16;
   localparam int BANDS_PER_LEVEL = 3;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic {
      MODE_STD_DEV = 1'b0,
      MODE_ENERGY  = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FEATURE_MODE    = 2'd0,
      CSR_LEVEL_COUNT     = 2'd1,
      CSR_WIDTH_EXPONENT  = 2'd2,
      CSR_HEIGHT_EXPONENT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BAND_HH = 2'd0,
      BAND_LH = 2'd1,
      BAND_HL = 2'd2
   } band_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_DIFF,
      ST_SCALE,
      ST_ROOT,
      ST_EMIT
   } fin_state_type;

endpackage

>>> sv/wss_if.sv
// coefficient / finish words
interface wss_req_if import wss_pkg::*; #(
   parameter int COEF_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [POS_W-1:0]            pos_x;
   logic [POS_W-1:0]            pos_y;
   logic signed [COEF_BITS-1:0] coef;

   modport source (output valid, op, pos_x, pos_y, coef, input ready);
   modport sink   (input valid, op, pos_x, pos_y, coef, output ready);
endinterface

// feature words
interface wss_rsp_if import wss_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FEAT_W-1:0] feature;
   logic [FIDX_W-1:0] feature_index;
   logic              last;

   modport source (output valid, feature, feature_index, last, input ready);
   modport sink   (input valid, feature, feature_index, last, output ready);
endinterface

// register write words
interface wss_csr_if import wss_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/wss_isqrt.sv
// Digit-recurrence integer square root, one result bit per cycle.
module wss_isqrt #(
   parameter int RAD_W = 75
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [RAD_W-1:0]           radicand,
   output logic                       done,
   output logic [(RAD_W+1)/2-1:0]     root
);

   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int PAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [PAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [REM_W-1:0]  rem_sh_c;
   logic [REM_W-1:0]  trial_c;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;

   // one step: bring down two bits, try subtracting 4*root+1
   always_comb begin
      rem_sh_c = {rem_ff[REM_W-3:0], rad_ff[PAD_W-1 -: 2]};
      trial_c  = REM_W'({root_ff, 2'b01});
      if (rem_sh_c >= trial_c) begin
         rem_in  = rem_sh_c - trial_c;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh_c;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= PAD_W'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[PAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> sv/wavelet_subband_statistics.sv
// Wavelet subband statistics. Coefficient words carry an (x, y) position and a
// value; each is filed into the detail band of the first decomposition level
// that holds it, where a saturating sum and sum of squares are kept in two
// small synchronous memories (3 entries per level). Outside a finish, a coefficient
// word is taken every cycle: the band lookup and memory read happen on acceptance,
// the add and write-back in the next cycle, with the last write forwarded to the
// next read. A finish word stops intake and emits 3*levels feature words in
// index order, then empties the store (per-entry valid bits, so there is no
// clearing pass after reset or finish). In energy mode each feature passes the
// read, load and emit states; in std-dev mode also multiply, difference, scale
// and the one-bit-per-cycle square root before it is emitted.
// Registers may be written only while the block is idle.
module wavelet_subband_statistics import wss_pkg::*; #(
   parameter int MAX_LEVELS        = 8,
   parameter int MAX_SIZE_EXPONENT = 8,
   parameter int COEF_BITS         = 16
) (
   input  logic      clock,
   input  logic      reset,
   wss_req_if.sink   req_ch,
   wss_rsp_if.source rsp_ch,
   wss_csr_if.sink   csr_ch
);

   localparam int BANDS   = BANDS_PER_LEVEL * MAX_LEVELS;
   localparam int IDX_W   = $clog2(BANDS);
   localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
   localparam int EXP_W   = $clog2(MAX_SIZE_EXPONENT + 1);
   localparam int XW      = (MAX_SIZE_EXPONENT > POS_W) ? MAX_SIZE_EXPONENT : POS_W;
   localparam int MAXLOG  = 2 * MAX_SIZE_EXPONENT - 2;
   localparam int LOG_W   = $clog2(MAXLOG + 1);
   localparam int SQR_W   = 2 * COEF_BITS - 1;
   localparam int ACC_W   = ((SQR_W > SQ_W) ? SQR_W : SQ_W) + 1;
   localparam int B_W     = 2 * SUM_W;
   localparam int D_W     = SQ_W + MAXLOG;
   localparam int CMP_W   = (D_W > B_W) ? D_W : B_W;
   localparam int RAD_W   = D_W + FRAC_SHIFT;
   localparam int ROOT_W  = (RAD_W + 1) / 2;

   // ------------------------------------------------------------------
   // configuration registers
   logic                  feature_mode_ff;
   logic [CSR_DATA_W-1:0] level_count_ff;
   logic [CSR_DATA_W-1:0] width_exponent_ff;
   logic [CSR_DATA_W-1:0] height_exponent_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         feature_mode_ff    <= MODE_ENERGY;
         level_count_ff     <= CSR_DATA_W'(3);
         width_exponent_ff  <= CSR_DATA_W'(8);
         height_exponent_ff <= CSR_DATA_W'(8);
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_FEATURE_MODE:    feature_mode_ff    <= csr_ch.data[0];
            CSR_LEVEL_COUNT:     level_count_ff     <= csr_ch.data;
            CSR_WIDTH_EXPONENT:  width_exponent_ff  <= csr_ch.data;
            CSR_HEIGHT_EXPONENT: height_exponent_ff <= csr_ch.data;
         endcase
      end
   end

   function automatic logic [EXP_W-1:0] clamp_exp(logic [CSR_DATA_W-1:0] e);
      logic [EXP_W-1:0] r;
      if (e == '0)
         r = EXP_W'(1);
      else if (int'(e) > MAX_SIZE_EXPONENT)
         r = EXP_W'(MAX_SIZE_EXPONENT);
      else
         r = EXP_W'(e);
      return r;
   endfunction

   logic [EXP_W-1:0]      we_c;
   logic [EXP_W-1:0]      he_c;
   logic [CSR_DATA_W-1:0] lvl_raw_c;
   logic [LVL_W-1:0]      levels_c;
   logic [IDX_W-1:0]      last_idx_c;

   // effective sizes and level count
   always_comb begin
      we_c      = clamp_exp(width_exponent_ff);
      he_c      = clamp_exp(height_exponent_ff);
      lvl_raw_c = level_count_ff;
      if (lvl_raw_c > CSR_DATA_W'(MAX_LEVELS)) lvl_raw_c = CSR_DATA_W'(MAX_LEVELS);
      if (lvl_raw_c > CSR_DATA_W'(we_c))       lvl_raw_c = CSR_DATA_W'(we_c);
      if (lvl_raw_c > CSR_DATA_W'(he_c))       lvl_raw_c = CSR_DATA_W'(he_c);
      if (lvl_raw_c == '0)                     lvl_raw_c = CSR_DATA_W'(1);
      levels_c   = LVL_W'(lvl_raw_c);
      last_idx_c = IDX_W'(BANDS_PER_LEVEL * int'(levels_c) - 1);
   end

   // ------------------------------------------------------------------
   // band lookup for an incoming coefficient
   logic [XW-1:0]    x_ext_c;
   logic [XW-1:0]    y_ext_c;
   logic [XW-1:0]    xs_c;
   logic [XW-1:0]    ys_c;
   logic [EXP_W-1:0] sh_x_c;
   logic [EXP_W-1:0] sh_y_c;
   logic             found_c;
   logic             hit_c;
   band_type         band_c;
   logic [IDX_W-1:0] band_idx_c;

   always_comb begin
      x_ext_c    = XW'(req_ch.pos_x);
      y_ext_c    = XW'(req_ch.pos_y);
      found_c    = 1'b0;
      hit_c      = 1'b0;
      band_c     = BAND_HH;
      band_idx_c = '0;
      sh_x_c     = '0;
      sh_y_c     = '0;
      xs_c       = '0;
      ys_c       = '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         sh_x_c = we_c - EXP_W'(k);
         sh_y_c = he_c - EXP_W'(k);
         xs_c   = x_ext_c >> (sh_x_c - 1'b1);
         ys_c   = y_ext_c >> (sh_y_c - 1'b1);
         if (!found_c && (LVL_W'(k) < levels_c)) begin
            if ((xs_c[XW-1:1] != '0) || (ys_c[XW-1:1] != '0)) begin
               // outside this level's region: ignored
               found_c = 1'b1;
            end else if (xs_c[0] || ys_c[0]) begin
               found_c = 1'b1;
               hit_c   = 1'b1;
               if (xs_c[0] && ys_c[0])
                  band_c = BAND_HH;
               else if (ys_c[0])
                  band_c = BAND_LH;
               else
                  band_c = BAND_HL;
               band_idx_c = IDX_W'(BANDS_PER_LEVEL * k) + IDX_W'(band_c);
            end
         end
      end
   end

   // coefficient square
   logic [COEF_BITS-1:0]   coef_mag_c;
   logic [2*COEF_BITS-1:0] coef_sq_c;

   always_comb begin
      coef_mag_c = req_ch.coef[COEF_BITS-1] ? COEF_BITS'(-req_ch.coef)
                                            : COEF_BITS'(req_ch.coef);
      coef_sq_c  = coef_mag_c * coef_mag_c;
   end

   // ------------------------------------------------------------------
   // control signals
   fin_state_type state_ff;
   fin_state_type state_in;
   logic          req_accept_c;
   logic          is_finish_c;
   logic          rd_en_c;
   logic [IDX_W-1:0] rd_addr_c;
   logic          sqrt_start_c;
   logic          sqrt_done;
   logic          last_c;
   logic [IDX_W-1:0] fin_idx_ff;

   assign req_ch.ready = (state_ff == ST_RUN);
   assign req_accept_c = req_ch.valid && req_ch.ready;
   assign is_finish_c  = (op_type'(req_ch.op) == OP_FINISH);
   assign last_c       = (fin_idx_ff == last_idx_c);

   // ------------------------------------------------------------------
   // band store: two memories, valid bits, write forwarding
   logic signed [SUM_W-1:0] sum_mem [BANDS];
   logic [SQ_W-1:0]         sq_mem  [BANDS];
   logic [BANDS-1:0]        entry_valid_ff;

   logic signed [SUM_W-1:0] sum_rd_ff;
   logic [SQ_W-1:0]         sq_rd_ff;
   logic                    rd_valid_ff;
   logic [IDX_W-1:0]        rd_addr_ff;

   logic                    fwd_valid_ff;
   logic [IDX_W-1:0]        fwd_addr_ff;
   logic signed [SUM_W-1:0] fwd_sum_ff;
   logic [SQ_W-1:0]         fwd_sq_ff;

   logic                    wr_en_c;
   logic [IDX_W-1:0]        wr_addr_c;
   logic signed [SUM_W-1:0] wr_sum_c;
   logic [SQ_W-1:0]         wr_sq_c;

   logic signed [SUM_W-1:0] cur_sum_c;
   logic [SQ_W-1:0]         cur_sq_c;

   always_ff @(posedge clock) begin
      if (rd_en_c) begin
         sum_rd_ff  <= sum_mem[rd_addr_c];
         sq_rd_ff   <= sq_mem[rd_addr_c];
         rd_addr_ff <= rd_addr_c;
      end
      if (wr_en_c) begin
         sum_mem[wr_addr_c] <= wr_sum_c;
         sq_mem[wr_addr_c]  <= wr_sq_c;
      end
      fwd_addr_ff <= wr_addr_c;
      fwd_sum_ff  <= wr_sum_c;
      fwd_sq_ff   <= wr_sq_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en_c;
         if (rd_en_c)
            rd_valid_ff <= entry_valid_ff[rd_addr_c];
         if (state_ff == ST_EMIT && rsp_ch.ready && last_c)
            entry_valid_ff <= '0;
         else if (wr_en_c)
            entry_valid_ff[wr_addr_c] <= 1'b1;
      end
   end

   // read data: forwarded write, stored entry, or empty
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         cur_sum_c = fwd_sum_ff;
         cur_sq_c  = fwd_sq_ff;
      end else if (rd_valid_ff) begin
         cur_sum_c = sum_rd_ff;
         cur_sq_c  = sq_rd_ff;
      end else begin
         cur_sum_c = '0;
         cur_sq_c  = '0;
      end
   end

   // ------------------------------------------------------------------
   // accumulate stage
   logic                        s2_valid_ff;
   logic [IDX_W-1:0]            s2_idx_ff;
   logic signed [COEF_BITS-1:0] s2_coef_ff;
   logic [SQR_W-1:0]            s2_sq_ff;

   logic signed [SUM_W:0]       sum_add_c;
   logic [ACC_W-1:0]            sq_add_c;

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else
         s2_valid_ff <= req_accept_c && !is_finish_c && hit_c;
   end

   always_ff @(posedge clock) begin
      if (req_accept_c) begin
         s2_idx_ff  <= band_idx_c;
         s2_coef_ff <= req_ch.coef;
         s2_sq_ff   <= coef_sq_c[SQR_W-1:0];
      end
   end

   // saturating sums
   always_comb begin
      sum_add_c = (SUM_W+1)'(cur_sum_c) + (SUM_W+1)'(s2_coef_ff);
      if (sum_add_c[SUM_W] != sum_add_c[SUM_W-1])
         wr_sum_c = sum_add_c[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
      else
         wr_sum_c = sum_add_c[SUM_W-1:0];
      sq_add_c = ACC_W'(cur_sq_c) + ACC_W'(s2_sq_ff);
      if (sq_add_c > ACC_W'({SQ_W{1'b1}}))
         wr_sq_c = {SQ_W{1'b1}};
      else
         wr_sq_c = sq_add_c[SQ_W-1:0];
      wr_en_c   = s2_valid_ff;
      wr_addr_c = s2_idx_ff;
   end

   // ------------------------------------------------------------------
   // finish sequencer
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_RUN;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in     = state_ff;
      rd_en_c      = 1'b0;
      rd_addr_c    = band_idx_c;
      sqrt_start_c = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (req_accept_c) begin
               if (is_finish_c)
                  state_in = ST_READ;
               else
                  rd_en_c = hit_c;
            end
         end
         ST_READ: begin
            rd_en_c   = 1'b1;
            rd_addr_c = fin_idx_ff;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = (mode_type'(feature_mode_ff) == MODE_ENERGY) ? ST_EMIT : ST_MUL;
         end
         ST_MUL:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SCALE;
         ST_SCALE: begin
            sqrt_start_c = 1'b1;
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ch.ready) state_in = last_c ? ST_RUN : ST_READ;
         end
      endcase
   end

   // feature datapath
   logic [LVL_W-1:0]        fin_lvl_ff;
   band_type                fin_band_ff;
   logic signed [SUM_W-1:0] fsum_ff;
   logic [SQ_W-1:0]         fsq_ff;
   logic [B_W-1:0]          b_ff;
   logic [D_W-1:0]          a_ff;
   logic [D_W-1:0]          d_ff;
   logic                    d_pos_ff;
   logic [FEAT_W-1:0]       feat_ff;

   logic [LOG_W-1:0]        log2n_c;
   logic [LOG_W:0]          shift_c;
   logic [SUM_W-1:0]        fmag_c;
   logic [CMP_W:0]          diff_c;
   logic [RAD_W-1:0]        rad_c;
   logic [ROOT_W-1:0]       sqrt_root;

   // band area exponent and variance scaling
   always_comb begin
      log2n_c = LOG_W'(we_c) + LOG_W'(he_c) - LOG_W'({fin_lvl_ff, 1'b0}) - LOG_W'(2);
      shift_c = {log2n_c, 1'b0};
      fmag_c  = fsum_ff[SUM_W-1] ? SUM_W'(-fsum_ff) : SUM_W'(fsum_ff);
      diff_c  = {1'b0, CMP_W'(a_ff)} - {1'b0, CMP_W'(b_ff)};
      if (!d_pos_ff)
         rad_c = '0;
      else if (int'(shift_c) <= FRAC_SHIFT)
         rad_c = RAD_W'(d_ff) << (FRAC_SHIFT - int'(shift_c));
      else
         rad_c = RAD_W'(d_ff >> (int'(shift_c) - FRAC_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_idx_ff  <= '0;
         fin_lvl_ff  <= '0;
         fin_band_ff <= BAND_HH;
      end else begin
         if (state_ff == ST_RUN && req_accept_c && is_finish_c) begin
            fin_idx_ff  <= '0;
            fin_lvl_ff  <= '0;
            fin_band_ff <= BAND_HH;
         end else if (state_ff == ST_EMIT && rsp_ch.ready && !last_c) begin
            fin_idx_ff <= fin_idx_ff + 1'b1;
            unique case (fin_band_ff)
               BAND_HH: fin_band_ff <= BAND_LH;
               BAND_LH: fin_band_ff <= BAND_HL;
               BAND_HL: begin
                  fin_band_ff <= BAND_HH;
                  fin_lvl_ff  <= fin_lvl_ff + 1'b1;
               end
               default: fin_band_ff <= BAND_HH;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_LOAD: begin
            fsum_ff <= cur_sum_c;
            fsq_ff  <= cur_sq_c;
            feat_ff <= FEAT_W'(cur_sq_c);
         end
         ST_MUL: begin
            b_ff <= fmag_c * fmag_c;
            a_ff <= D_W'(fsq_ff) << log2n_c;
         end
         ST_DIFF: begin
            d_pos_ff <= !diff_c[CMP_W] && (diff_c != '0);
            d_ff     <= D_W'(diff_c);
         end
         ST_ROOT: begin
            if (sqrt_done) feat_ff <= FEAT_W'(sqrt_root);
         end
         default: ;
      endcase
   end

   wss_isqrt #(
      .RAD_W (RAD_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_c),
      .radicand (rad_c),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // result word
   assign rsp_ch.valid         = (state_ff == ST_EMIT);
   assign rsp_ch.feature       = feat_ff;
   assign rsp_ch.feature_index = FIDX_W'(fin_idx_ff);
   assign rsp_ch.last          = last_c;

   // ------------------------------------------------------------------
   // checks
   a_no_intake_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("input taken while a feature word is pending");

   a_no_write_during_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN && state_ff != ST_READ) |-> !s2_valid_ff)
      else $error("store write during feature readout");

   a_store_empty_after_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> (entry_valid_ff == '0))
      else $error("store not emptied after the last feature");

   a_root_done_in_root_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == ST_ROOT))
      else $error("square root finished outside the root state");

endmodule

>>> sim/wavelet_subband_statistics_tb.sv
`timescale 1ns / 100ps

module wavelet_subband_statistics_tb;
   import wss_pkg::*;

   localparam int MAX_LEVELS    = 8;
   localparam int MAX_EXP       = 8;
   localparam int COEF_BITS     = 16;
   localparam int BAND_COUNT    = BANDS_PER_LEVEL * MAX_LEVELS;
   localparam longint unsigned ENERGY_MAX = (64'd1 << SQ_W) - 64'd1;
   localparam longint SUM_HI    = 64'sd2147483647;
   localparam longint SUM_LO    = -64'sd2147483648;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 20;
   localparam int PRINT_CAP     = 40;

   typedef struct {
      logic [FEAT_W-1:0] feature;
      logic [FIDX_W-1:0] index;
      logic              last;
   } feature_word_t;

   typedef enum logic {
      ROW_WORD,
      ROW_REG
   } row_kind_e;

   // one row of directed stimulus: a data word or a register write
   typedef struct packed {
      row_kind_e             kind;
      csr_index_type         reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      op_type                op;
      logic [POS_W-1:0]      x;
      logic [POS_W-1:0]      y;
      logic signed [15:0]    coef;
      logic                  typed;
      logic [FEAT_W-1:0]     feat0;
   } stim_row_t;

   logic clock;
   logic reset;

   wss_req_if #(.COEF_BITS(COEF_BITS)) req_ch ();
   wss_rsp_if rsp_ch ();
   wss_csr_if csr_ch ();

   wavelet_subband_statistics #(
      .MAX_LEVELS       (MAX_LEVELS),
      .MAX_SIZE_EXPONENT(MAX_EXP),
      .COEF_BITS        (COEF_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // shadow registers and band store
   mode_type               cfg_mode;
   logic [CSR_DATA_W-1:0]  cfg_levels;
   logic [CSR_DATA_W-1:0]  cfg_wexp;
   logic [CSR_DATA_W-1:0]  cfg_hexp;
   longint                 band_total  [BAND_COUNT];
   longint unsigned        band_energy [BAND_COUNT];

   feature_word_t pending_features[$];

   int  mismatch_count  = 0;
   int  words_sent      = 0;
   int  finishes_sent   = 0;
   int  features_checked = 0;
   int  settings_used   = 0;
   bit  quiet           = 1'b0;
   bit  hold_request    = 1'b0;

   // columns: kind, register, value, op, x, y, coef, typed, feature 0
   stim_row_t directed_rows [31] = '{
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd255, 8'd255, 16'sh8000, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd0,   8'd255, 16'sh7fff, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd255, 8'd0,   16'sd1,    1'b0, 45'd0},
      // coarsest low-low region: dropped
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd0,   8'd0,   16'sd5,    1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd100, 8'd40,  -16'sd7,   1'b0, 45'd0},
      // energy of HH at level 0 after reset: 32768^2
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_FINISH, 8'd255, 8'd255, -16'sd1,   1'b1,
        45'd1073741824},
      '{ROW_REG,  CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_WIDTH_EXPONENT,  4'd1,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_HEIGHT_EXPONENT, 4'd1,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      // same position twice on a 2x2 image: sum^2 exceeds n*sumsq
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd1,   8'd1,   16'sd100,  1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd1,   8'd1,   16'sd100,  1'b0, 45'd0},
      // outside the image: dropped
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd2,   8'd2,   16'sd77,   1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd1,   8'd0,   16'sh8000, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_FINISH, 8'd0,   8'd0,   16'sd0,    1'b1, 45'd0},
      // out-of-range level count and exponents are clamped
      '{ROW_REG,  CSR_LEVEL_COUNT,     4'd15, OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_WIDTH_EXPONENT,  4'd15, OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_HEIGHT_EXPONENT, 4'd0,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd255, 8'd1,   16'sh7fff, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd3,   8'd0,   -16'sd1,   1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd200, 8'd0,   16'sd12345, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_FINISH, 8'd17,  8'd34,  16'sd1,    1'b0, 45'd0},
      '{ROW_REG,  CSR_FEATURE_MODE,    4'd15, OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_LEVEL_COUNT,     4'd8,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_WIDTH_EXPONENT,  4'd8,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      '{ROW_REG,  CSR_HEIGHT_EXPONENT, 4'd8,  OP_SAMPLE, 8'd0,   8'd0,   16'sd0,    1'b0, 45'd0},
      // deepest level bands
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd1,   8'd1,   -16'sd300, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd0,   8'd1,   16'sd9,    1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd1,   8'd0,   -16'sd2,   1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd0,   8'd0,   16'sd4444, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_SAMPLE, 8'd127, 8'd200, 16'sh8000, 1'b0, 45'd0},
      '{ROW_WORD, CSR_FEATURE_MODE,    4'd0,  OP_FINISH, 8'd170, 8'd85,  16'shaaaa, 1'b1, 45'd0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clamp_exp(logic [CSR_DATA_W-1:0] e);
      if (e < 1) return 1;
      if (e > MAX_EXP) return MAX_EXP;
      return int'(e);
   endfunction

   function automatic int active_levels(int we, int he);
      int lv = int'(cfg_levels);
      if (lv > MAX_LEVELS) lv = MAX_LEVELS;
      if (lv > we) lv = we;
      if (lv > he) lv = he;
      if (lv < 1) lv = 1;
      return lv;
   endfunction

   // Q.8 std dev: isqrt(((n*sumsq - sum^2) << 16) >> 2*log2n), zero if not positive
   function automatic logic [FEAT_W-1:0] std_q8(longint total, longint unsigned energy,
                                                int log2n);
      logic [127:0] mag, scaled_n, spread, scaled, rest, root, trial;
      int s;
      mag = (total < 0) ? 128'(-total) : 128'(total);
      scaled_n = 128'(energy) << log2n;
      if (scaled_n <= mag * mag) return '0;
      spread = scaled_n - mag * mag;
      s = 2 * log2n;
      scaled = (s <= FRAC_SHIFT) ? spread << (FRAC_SHIFT - s) : spread >> (s - FRAC_SHIFT);
      root = '0;
      rest = '0;
      for (int p = 126; p >= 0; p -= 2) begin
         rest = (rest << 2) | ((scaled >> p) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rest >= trial) begin
            rest = rest - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[FEAT_W-1:0];
   endfunction

   // file a coefficient into the band of the first level that holds it
   task automatic file_coefficient(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                   logic signed [15:0] c);
      int we, he, lv, bnd, idx;
      longint unsigned rw, rh, hw, hh, mag, nrg;
      longint acc;
      we = clamp_exp(cfg_wexp);
      he = clamp_exp(cfg_hexp);
      lv = active_levels(we, he);
      for (int k = 0; k < lv; k++) begin
         rw = 64'd1 << (we - k);
         rh = 64'd1 << (he - k);
         hw = rw >> 1;
         hh = rh >> 1;
         if (x >= rw || y >= rh) break;
         if (x >= hw && y >= hh) bnd = int'(BAND_HH);
         else if (x < hw && y >= hh) bnd = int'(BAND_LH);
         else if (x >= hw && y < hh) bnd = int'(BAND_HL);
         else continue;
         idx = BANDS_PER_LEVEL * k + bnd;
         acc = band_total[idx] + longint'(c);
         if (acc > SUM_HI) acc = SUM_HI;
         if (acc < SUM_LO) acc = SUM_LO;
         band_total[idx] = acc;
         mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
         nrg = band_energy[idx] + mag * mag;
         if (nrg > ENERGY_MAX) nrg = ENERGY_MAX;
         band_energy[idx] = nrg;
         break;
      end
   endtask

   // queue the feature words of a finish, then empty the store
   task automatic emit_features(logic typed, logic [FEAT_W-1:0] feat0);
      int we, he, lv, idx;
      feature_word_t w;
      we = clamp_exp(cfg_wexp);
      he = clamp_exp(cfg_hexp);
      lv = active_levels(we, he);
      for (int k = 0; k < lv; k++) begin
         for (int b = 0; b < BANDS_PER_LEVEL; b++) begin
            idx = BANDS_PER_LEVEL * k + b;
            if (cfg_mode == MODE_ENERGY) w.feature = band_energy[idx][FEAT_W-1:0];
            else w.feature = std_q8(band_total[idx], band_energy[idx],
                                    (we - k - 1) + (he - k - 1));
            if (typed && idx == 0) w.feature = feat0;
            w.index = FIDX_W'(idx);
            w.last  = (idx == BANDS_PER_LEVEL * lv - 1);
            pending_features.push_back(w);
         end
      end
      for (int i = 0; i < BAND_COUNT; i++) begin
         band_total[i]  = 0;
         band_energy[i] = 0;
      end
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("ERROR %0t: %s", $realtime, what);
   endtask

   // offer one word, with random idle cycles first; returns at acceptance
   task automatic send_word(op_type op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic signed [15:0] c, logic typed, logic [FEAT_W-1:0] feat0);
      bit stall;
      stall = !quiet && ($urandom_range(99) < 17);
      while (stall) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         stall = !quiet && ($urandom_range(99) < 17);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.pos_x <= x;
      req_ch.pos_y <= y;
      req_ch.coef  <= c;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (op == OP_SAMPLE) begin
         file_coefficient(x, y, c);
      end else begin
         finishes_sent++;
         emit_features(typed, feat0);
      end
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_FEATURE_MODE:    cfg_mode   = mode_type'(value[0]);
         CSR_LEVEL_COUNT:     cfg_levels = value;
         CSR_WIDTH_EXPONENT:  cfg_wexp   = value;
         CSR_HEIGHT_EXPONENT: cfg_hexp   = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (pending_features.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_all(logic [3:0] mode_v, logic [3:0] lvl_v, logic [3:0] w_v,
                            logic [3:0] h_v);
      write_register(CSR_FEATURE_MODE, mode_v);
      write_register(CSR_LEVEL_COUNT, lvl_v);
      write_register(CSR_WIDTH_EXPONENT, w_v);
      write_register(CSR_HEIGHT_EXPONENT, h_v);
      settings_used++;
   endtask

   // mostly positions inside a chosen band, the rest anywhere
   task automatic pick_position(output logic [POS_W-1:0] x, output logic [POS_W-1:0] y);
      int we, he, lv, k, bnd, hw, hh;
      we = clamp_exp(cfg_wexp);
      he = clamp_exp(cfg_hexp);
      lv = active_levels(we, he);
      k = $urandom_range(lv - 1);
      bnd = $urandom_range(BANDS_PER_LEVEL - 1);
      hw = (1 << (we - k)) >> 1;
      hh = (1 << (he - k)) >> 1;
      if ($urandom_range(99) < 25) begin
         x = POS_W'($urandom_range(255));
         y = POS_W'($urandom_range(255));
      end else begin
         x = POS_W'((bnd != int'(BAND_LH)) ? hw + $urandom_range(hw - 1) : $urandom_range(hw - 1));
         y = POS_W'((bnd != int'(BAND_HL)) ? hh + $urandom_range(hh - 1) : $urandom_range(hh - 1));
      end
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(19))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sd0;
         3:       return -16'sd1;
         4:       return 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_exp();
      if ($urandom_range(9) == 0) return 4'($urandom_range(15));
      return 4'($urandom_range(1, MAX_EXP));
   endfunction

   // result side: random back-pressure, plus one long hold-off on request
   initial begin : feature_sink
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
         end
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 17);
      end
   end

   // compare each feature word with the oldest expectation
   always @(posedge clock) begin : feature_check
      feature_word_t w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         features_checked++;
         if (pending_features.size() == 0) begin
            report_mismatch($sformatf("unexpected feature word, index %0d",
                                      rsp_ch.feature_index));
         end else begin
            w = pending_features.pop_front();
            if (rsp_ch.feature !== w.feature)
               report_mismatch($sformatf("feature %0d: got %0d, want %0d",
                                         w.index, rsp_ch.feature, w.feature));
            if (rsp_ch.feature_index !== w.index)
               report_mismatch($sformatf("feature_index: got %0d, want %0d",
                                         rsp_ch.feature_index, w.index));
            if (rsp_ch.last !== w.last)
               report_mismatch($sformatf("last on feature %0d: got %b, want %b",
                                         w.index, rsp_ch.last, w.last));
         end
      end
   end

   // end the run if no channel moves a word for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles, %0d features outstanding",
               STALL_LIMIT, pending_features.size());
      $display("Mismatches found");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      stim_row_t row;
      logic [POS_W-1:0] px, py;
      op_type op;
      bit was_word;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_SAMPLE;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.coef  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_FEATURE_MODE;
      csr_ch.data  <= '0;
      cfg_mode   = MODE_ENERGY;
      cfg_levels = 4'd3;
      cfg_wexp   = 4'd8;
      cfg_hexp   = 4'd8;
      for (int i = 0; i < BAND_COUNT; i++) begin
         band_total[i]  = 0;
         band_energy[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      was_word = 1'b0;
      settings_used = 1;
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_REG) begin
            if (was_word) begin
               req_ch.valid <= 1'b0;
               wait_drain();
               settings_used++;
            end
            write_register(row.reg_idx, row.reg_val);
            was_word = 1'b0;
         end else begin
            send_word(row.op, row.x, row.y, row.coef, row.typed, row.feat0);
            was_word = 1'b1;
         end
      end
      req_ch.valid <= 1'b0;
      wait_drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       write_all(4'd0, 4'd8, 4'd8, 4'd8);
            1:       write_all(4'd1, 4'd1, 4'd1, 4'd1);
            default: write_all(4'($urandom_range(15)), 4'($urandom_range(15)),
                               pick_exp(), pick_exp());
         endcase
         quiet = (ph == 3);
         if (ph == 2) hold_request = 1'b1;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            op = (i % 7 == 6 || i == PHASE_WORDS - 1 || $urandom_range(99) < 8) ?
                 OP_FINISH : OP_SAMPLE;
            pick_position(px, py);
            send_word(op, px, py, pick_coef(), 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
         wait_drain();
      end

      // long accumulations on one position: saturated sums give a zero std dev,
      // saturated sum of squares shows as the energy ceiling
      quiet = 1'b1;
      write_all(4'd0, 4'd3, 4'd8, 4'd8);
      for (int i = 0; i < 66000; i++) send_word(OP_SAMPLE, 8'd255, 8'd255, 16'sh8000, 1'b0, '0);
      send_word(OP_FINISH, 8'd0, 8'd0, 16'sd0, 1'b1, '0);
      req_ch.valid <= 1'b0;
      wait_drain();
      write_register(CSR_FEATURE_MODE, 4'd1);
      for (int i = 0; i < 33000; i++) send_word(OP_SAMPLE, 8'd255, 8'd255, 16'sh8000, 1'b0, '0);
      send_word(OP_FINISH, 8'd0, 8'd0, 16'sd0, 1'b1, ENERGY_MAX[FEAT_W-1:0]);
      req_ch.valid <= 1'b0;
      quiet = 1'b0;
      wait_drain();

      $display("Run covered %0d words (%0d finishes) over %0d register settings,",
               words_sent, finishes_sent, settings_used + 1);
      $display("%0d features compared, incl. an output hold-off and saturating sums.",
               features_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
